### design/fir_fdf_pkg.sv
// Package for the direct-form FIR filter: widths, item codes, state codes and
// the control struct passed from the sequencer to the multiply-accumulate unit.
// No dependencies.
package fir_fdf_pkg;

    localparam int DEF_TAPS  = 100;
    localparam int IDX_W     = 7;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = 40;

    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    // One tap step entering the multiply-accumulate pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

### design/fir_filter_direct_form.sv
// Top level of the streaming direct-form FIR filter: sequencer, output register
// and the coefficient, delay-line and multiply-accumulate units.
// Depends on fir_fdf_pkg, fir_fdf_coef_store, fir_fdf_delay_store, fir_fdf_mac.
//
//   Channel | Direction | Handshake          | Payload
//   s_      | in        | s_valid / s_ready  | s_cmd, s_tap_index, s_coef_value, s_sample
//   m_      | out       | m_valid / m_ready  | m_filtered
//
// A coefficient item is written on acceptance and leaves the filter ready for the next
// item. A sample item has its result loaded into the output register once the tap pass
// has drained, and the next item is taken after that load. The pass is paced by the single
// multiply-accumulate stepping one tap per cycle through the two memories' read ports.
// Reset (aresetn low, synchronous) clears the valid bits and the fill count;
// there is no clearing pass. A result waiting on m_ready does not
// stop the next item from being accepted; a following result then holds in the
// accumulator until the output register frees up.
module fir_filter_direct_form
    import fir_fdf_pkg::*;
#(
    parameter int TAPS = DEF_TAPS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  logic [IDX_W-1:0]           s_tap_index,
    input  logic signed [COEF_W-1:0]   s_coef_value,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [ACC_W-1:0]    m_filtered
);

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW    = $clog2(TAPS + 1);
    localparam int CMP_W = (CW > IDX_W) ? CW : IDX_W;

    state_t                     state_reg, state_next;
    logic [AW-1:0]              k_reg, k_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [ACC_W-1:0]    m_filtered_reg;

    logic                       accept;
    logic                       coef_wr;
    logic                       push;
    logic [CMP_W-1:0]           idx_ext;
    logic                       last_tap;
    logic                       out_free;
    logic                       out_load;
    mac_ctl_t                   issue;
    logic signed [COEF_W-1:0]   coef_rd;
    logic signed [SAMPLE_W-1:0] sample_rd;
    logic                       mac_done;
    logic signed [ACC_W-1:0]    mac_acc;

    // Items are taken only between sample computations, so a memory write
    // never overlaps a read pass of the same store.
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Coefficient positions beyond the tap count are dropped.
    assign idx_ext = CMP_W'(s_tap_index);
    assign coef_wr = accept && (s_cmd == CMD_COEF) && (idx_ext < CMP_W'(TAPS));
    assign push    = accept && (s_cmd == CMD_SAMPLE);

    assign last_tap = (k_reg == AW'(TAPS - 1));

    // Each RUN cycle reads coefficient k and the sample k steps old.
    assign issue.valid = (state_reg == ST_RUN);
    assign issue.first = (k_reg == '0);
    assign issue.last  = last_tap;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                k_next = '0;
                if (push) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                k_next = k_reg + 1'b1;
                if (last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The final sum comes once the last tap issue passes the align, product and accumulator registers.
                if (mac_done) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_filtered_reg <= mac_acc;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;

    fir_fdf_coef_store #(
        .TAPS (TAPS)
    ) u_coef (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (coef_wr),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data (s_coef_value),
        .rd_addr (k_reg),
        .rd_data (coef_rd)
    );

    fir_fdf_delay_store #(
        .TAPS (TAPS)
    ) u_delay (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_sample (s_sample),
        .rd_age      (k_reg),
        .rd_data     (sample_rd)
    );

    fir_fdf_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .coef    (coef_rd),
        .sample  (sample_rd),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    // The accumulator finishes only while the sequencer waits for it.
    a_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == ST_DRAIN))
        else $error("sum finished outside the drain state");

    // A new result never overwrites one that has not been taken.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

    // A sample item starts the tap pass from tap zero.
    a_push_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (state_reg == ST_RUN) && (k_reg == '0))
        else $error("sample item did not start a tap pass");

endmodule

### design/fir_fdf_coef_store.sv
// Coefficient memory of the FIR filter with per-entry valid bits.
// Unwritten entries read as zero. Depends on fir_fdf_pkg.
module fir_fdf_coef_store
    import fir_fdf_pkg::*;
#(
    parameter int TAPS = DEF_TAPS,
    localparam int AW  = (TAPS > 1) ? $clog2(TAPS) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [COEF_W-1:0] wr_data,
    input  logic [AW-1:0]            rd_addr,
    output logic signed [COEF_W-1:0] rd_data
);

    logic [COEF_W-1:0] mem [TAPS];
    logic [TAPS-1:0]   valid_reg;
    logic [COEF_W-1:0] data_reg;
    logic              ok_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ok_reg    <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            ok_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = ok_reg ? $signed(data_reg) : '0;

endmodule

### design/fir_fdf_delay_store.sv
// Delay line of the FIR filter held as a circular buffer in one memory.
// A fill count masks entries older than the samples pushed since reset.
// Depends on fir_fdf_pkg.
module fir_fdf_delay_store
    import fir_fdf_pkg::*;
#(
    parameter int TAPS = DEF_TAPS,
    localparam int AW  = (TAPS > 1) ? $clog2(TAPS) : 1,
    localparam int CW  = $clog2(TAPS + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic signed [SAMPLE_W-1:0] push_sample,
    input  logic [AW-1:0]              rd_age,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [TAPS];
    logic [AW-1:0]       newest_reg, newest_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [SAMPLE_W-1:0] data_reg;
    logic                ok_reg;
    logic [AW:0]         diff;
    logic [AW:0]         wrapped;
    logic [AW-1:0]       rd_addr;

    assign newest_next = (newest_reg == AW'(TAPS - 1)) ? '0 : newest_reg + 1'b1;
    assign fill_next   = (fill_reg == CW'(TAPS)) ? fill_reg : fill_reg + 1'b1;

    // Address of the sample rd_age steps older than the newest one.
    assign diff    = {1'b0, newest_reg} - {1'b0, rd_age};
    assign wrapped = diff + (AW+1)'(TAPS);
    assign rd_addr = diff[AW] ? wrapped[AW-1:0] : diff[AW-1:0];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[newest_next] <= push_sample;
        end
        data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_reg <= AW'(TAPS - 1);
            fill_reg   <= '0;
            ok_reg     <= 1'b0;
        end else begin
            if (push) begin
                newest_reg <= newest_next;
                fill_reg   <= fill_next;
            end
            ok_reg <= (CW'(rd_age) < fill_reg);
        end
    end

    assign rd_data = ok_reg ? $signed(data_reg) : '0;

endmodule

### design/fir_fdf_mac.sv
// Shared multiply-accumulate pipeline of the FIR filter: memory-read align,
// product register, accumulator. Depends on fir_fdf_pkg.
module fir_fdf_mac
    import fir_fdf_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mac_ctl_t                   issue,
    input  logic signed [COEF_W-1:0]   coef,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       done,
    output logic signed [ACC_W-1:0]    acc
);

    mac_ctl_t                  ctl1_reg, ctl2_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      done_reg;

    // The first product of a sample loads the accumulator instead of adding.
    assign acc_next = ctl2_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl1_reg <= issue;
            ctl2_reg <= ctl1_reg;
            done_reg <= ctl2_reg.valid && ctl2_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= coef * sample;
        if (ctl2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule
